// ----- src/uas_pkg.sv -----
// Shared types and constants for the undirected adjacency store.
// No dependencies.
`timescale 1ns / 1ps
package uas_pkg;
  // graph capacity; vertex numbers fill the 6-bit vertex field, degrees fit the 6-bit degree field
  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 32;

  localparam logic [1:0] KIND_ADD_EDGE = 2'd0;
  localparam logic [1:0] KIND_REMOVE   = 2'd1;
  localparam logic [1:0] KIND_ADD_VERT = 2'd2;
  localparam logic [1:0] KIND_LIST     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  // Result item; tdata holds it from bit 0 up as status first, so fields are listed here from the top bit down.
  typedef struct packed {
    logic [11:0] edge_count;
    logic [6:0]  vertex_count;
    logic [5:0]  removed;
    logic [5:0]  degree;
    logic [5:0]  neighbor;
    logic [1:0]  status;
  } result_t;
endpackage

// ----- src/undirected_adjacency_store.sv -----
// Undirected adjacency store: neighbor lists, degrees, vertex and edge counts.
// Add vertices, add edge and rejected operations give a single result. Remove scans
// the list of a, then of b (a self-loop scans one list), copying the last slot over
// each removed entry; list emits the neighbors of a one after another.
// One item at a time; s_tready stays low until the last result is handed on.
// Reset (rst, synchronous): vertex and edge counts clear; degrees clear at once via
// valid bits; neighbor memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module undirected_adjacency_store
  import uas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // kind[1:0], from_vertex[7:2], to_vertex[13:8], count[21:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // status, neighbor, degree, removed, vertex_count, edge_count
  output logic        m_tlast
);
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = VW + SW;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_CHECK, S_ADD_B, S_RM_RD, S_RM_CMP, S_RM_LAST, S_RM_WR, S_RM_NEXT,
    S_LS_RD, S_LS_EMIT, S_EMIT
  } state_t;

  state_t state;
  logic [1:0] kind;
  logic [5:0] va, vb;
  logic [7:0] cnt;
  logic [6:0] vertices;
  logic [11:0] edges;

  logic [5:0] mem [MAX_VERTICES*MAX_DEGREE];
  logic [5:0] rdata;
  logic       mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [5:0] mem_wd;

  logic [DW-1:0] deg [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] deg_ok;

  // remove scan state
  logic       side;      // 0: list of a, 1: list of b
  logic [5:0] cur_v, tgt;
  logic [DW-1:0] idx, n;
  logic [5:0] done, got;
  logic [5:0] hit;
  logic [1:0] res_status;
  logic [5:0] res_removed;

  result_t push_data;
  logic    push, push_last, full;

  function automatic logic [DW-1:0] deg_rd(input logic [DW-1:0] d, input logic ok);
    return ok ? d : '0;
  endfunction

  // degree table read port: registered degrees of va and vb
  logic [DW-1:0] deg_a, deg_b;
  logic in_a, in_b;
  assign in_a = (VW >= 6) || ({1'b0, va} < 7'(MAX_VERTICES));
  assign in_b = (VW >= 6) || ({1'b0, vb} < 7'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    deg_a <= in_a ? deg_rd(deg[va[VW-1:0]], deg_ok[va[VW-1:0]]) : '0;
    deg_b <= in_b ? deg_rd(deg[vb[VW-1:0]], deg_ok[vb[VW-1:0]]) : '0;
  end

  // add edge fits: both endpoints in range and neither list full
  logic add_ok;
  assign add_ok = in_a && in_b && (deg_a < DW'(MAX_DEGREE)) &&
                  (va == vb || deg_b < DW'(MAX_DEGREE));

  // degree as reported: zero when a is not a graph vertex
  logic [5:0] deg_rep;
  assign deg_rep = ({1'b0, va} < vertices && in_a) ? 6'(deg_a) : 6'd0;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  assign s_tready = (state == S_IDLE);
  logic [6:0] top1;
  assign top1 = (va > vb) ? {1'b0, va} + 7'd1 : {1'b0, vb} + 7'd1;
  logic [8:0] vsum;
  assign vsum = {2'b0, vertices} + {1'b0, cnt};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = {cur_v[VW-1:0], idx[SW-1:0]};
    case (state)
      S_CHECK: begin
        mem_we = (kind == KIND_ADD_EDGE) && add_ok;
        mem_wa = {va[VW-1:0], deg_a[SW-1:0]};
        mem_wd = vb;
      end
      S_ADD_B: begin
        mem_we = (va != vb);
        mem_wa = {vb[VW-1:0], deg_b[SW-1:0]};
        mem_wd = va;
      end
      S_RM_LAST: mem_ra = {cur_v[VW-1:0], SW'(n - DW'(1))};
      S_RM_WR: begin
        mem_we = 1'b1;
        mem_wa = {cur_v[VW-1:0], idx[SW-1:0]};
        mem_wd = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    push <= !rst && (state == S_LS_EMIT || (state == S_EMIT && !full && !push));
    if (rst) begin
      state    <= S_IDLE;
      vertices <= '0;
      edges    <= '0;
      deg_ok   <= '0;
    end else begin
      case (state)
        S_IDLE: if (s_tvalid) begin
          kind  <= s_tdata[1:0];
          va    <= s_tdata[7:2];
          vb    <= s_tdata[13:8];
          cnt   <= s_tdata[21:14];
          state <= S_FETCH;
        end
        // degree read of both endpoints
        S_FETCH: state <= S_CHECK;
        S_CHECK: begin
          res_removed <= '0;
          hit         <= '0;
          case (kind)
            KIND_ADD_EDGE: begin
              if (!in_a || !in_b) begin
                res_status <= ST_CAPACITY;
                state      <= S_EMIT;
              end else if (!add_ok) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else begin
                res_status         <= ST_OK;
                deg[va[VW-1:0]]    <= deg_a + DW'(1);
                deg_ok[va[VW-1:0]] <= 1'b1;
                if (top1 > vertices) vertices <= top1;
                edges <= edges + 12'd1;
                state <= S_ADD_B;
              end
            end
            KIND_REMOVE: begin
              if ({1'b0, va} >= vertices || {1'b0, vb} >= vertices) begin
                res_status <= ST_RANGE;
                state      <= S_EMIT;
              end else begin
                res_status <= ST_OK;
                side  <= 1'b0;
                cur_v <= va;
                tgt   <= vb;
                n     <= deg_a;
                idx   <= '0;
                done  <= '0;
                state <= S_RM_RD;
              end
            end
            KIND_ADD_VERT: begin
              state <= S_EMIT;
              if (vsum > 9'(MAX_VERTICES)) res_status <= ST_CAPACITY;
              else begin
                res_status <= ST_OK;
                vertices   <= vsum[6:0];
              end
            end
            default: begin
              if ({1'b0, va} >= vertices) begin
                res_status <= ST_RANGE;
                state      <= S_EMIT;
              end else if (deg_a != '0) begin
                res_status <= ST_OK;
                cur_v <= va;
                n     <= deg_a;
                idx   <= '0;
                state <= S_LS_RD;
              end else begin
                res_status <= ST_OK;
                state      <= S_EMIT;
              end
            end
          endcase
        end
        // second endpoint; a self-loop only passes through so the degree read settles
        S_ADD_B: begin
          if (va != vb) begin
            deg[vb[VW-1:0]]    <= deg_b + DW'(1);
            deg_ok[vb[VW-1:0]] <= 1'b1;
          end
          state <= S_EMIT;
        end
        // remove: read slot idx, compare, on match copy last slot over it
        S_RM_RD: begin
          if (idx >= n || {2'b0, done} >= cnt) begin
            deg[cur_v[VW-1:0]]    <= n;
            deg_ok[cur_v[VW-1:0]] <= 1'b1;
            if (!side) begin
              got <= done;
              if (va != vb) begin
                side  <= 1'b1;
                cur_v <= vb;
                tgt   <= va;
                idx   <= '0;
                done  <= '0;
                state <= S_RM_NEXT;
              end else begin
                state <= S_RM_NEXT;
                side  <= 1'b1;
                hit   <= done;
              end
            end else begin
              state <= S_RM_NEXT;
              hit   <= 6'h3f;
            end
          end else begin
            state <= S_RM_CMP;
          end
        end
        S_RM_CMP: begin
          if (rdata == tgt) state <= S_RM_LAST;
          else begin
            idx   <= idx + DW'(1);
            state <= S_RM_RD;
          end
        end
        S_RM_LAST: state <= S_RM_WR;
        S_RM_WR: begin
          n     <= n - DW'(1);
          done  <= done + 6'd1;
          state <= S_RM_RD;
        end
        S_RM_NEXT: begin
          // entered after finishing a list; decide whether second list runs
          if (side && hit == 6'h3f || (side && va == vb)) begin
            res_removed <= got;
            edges <= (edges >= {6'b0, got}) ? edges - {6'b0, got} : '0;
            state <= S_EMIT;
          end else begin
            n     <= deg_b;
            hit   <= '0;
            state <= S_RM_RD;
          end
        end
        S_LS_RD: if (!full && !push) state <= S_LS_EMIT;
        S_LS_EMIT: begin
          push_data <= '{edge_count: edges, vertex_count: vertices, removed: '0,
                         degree: 6'(n), neighbor: rdata, status: ST_OK};
          push_last <= (idx + DW'(1) == n);
          if (idx + DW'(1) == n) state <= S_IDLE;
          else begin
            idx   <= idx + DW'(1);
            state <= S_LS_RD;
          end
        end
        S_EMIT: if (!full && !push) begin
          push_last <= 1'b1;
          push_data <= '{edge_count: edges, vertex_count: vertices,
                         removed: res_removed,
                         degree: (kind == KIND_LIST) ? 6'd0 : deg_rep,
                         neighbor: 6'd0, status: res_status};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  result_t out_data;
  uas_out_reg u_out (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .push_last(push_last),
    .full(full), .tvalid(m_tvalid), .tready(m_tready), .data(out_data), .tlast(m_tlast)
  );
  assign m_tdata = {1'b0, out_data};
endmodule

// ----- src/uas_out_reg.sv -----
// Output holding register for result items.
// Depends on uas_pkg.
`timescale 1ns / 1ps
module uas_out_reg
  import uas_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    push_last,
  output logic    full,
  output logic    tvalid,
  input  logic    tready,
  output result_t data,
  output logic    tlast
);
  assign full = tvalid && !tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (push) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
    if (push) begin
      data  <= push_data;
      tlast <= push_last;
    end
  end
endmodule

// ----- dv/uas_checker.sv -----
// Checker for the undirected adjacency store: watches both streams, predicts
// results from its own graph model and compares them. Depends on uas_pkg.
`timescale 1ns / 1ps
module uas_checker
  import uas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  typedef struct packed {
    logic    lst;
    result_t res;
  } expected_t;

  expected_t expected_q[$];
  logic [5:0] adj_mem[MAX_VERTICES][MAX_DEGREE];
  int         deg_tab[MAX_VERTICES];
  int         vert_cnt;
  int         edge_cnt;

  assign pending = expected_q.size();

  function automatic int degree_of(int v);
    if (v < vert_cnt && v < MAX_VERTICES) return deg_tab[v];
    return 0;
  endfunction

  function automatic void push_result(logic [1:0] st, int nb, int dg, int rm, logic lst);
    expected_t e;
    e.res.status       = st;
    e.res.neighbor     = nb[5:0];
    e.res.degree       = dg[5:0];
    e.res.removed      = rm[5:0];
    e.res.vertex_count = vert_cnt[6:0];
    e.res.edge_count   = edge_cnt[11:0];
    e.lst              = lst;
    expected_q.push_back(e);
  endfunction

  // swap-with-last removal of up to lim copies of tgt from v's list
  function automatic int strip_matches(int v, int tgt, int lim);
    int n, i, done;
    n = deg_tab[v];
    i = 0;
    done = 0;
    while (i < n && done < lim) begin
      if (int'(adj_mem[v][i]) == tgt) begin
        adj_mem[v][i] = adj_mem[v][n-1];
        n--;
        done++;
      end else begin
        i++;
      end
    end
    deg_tab[v] = n;
    return done;
  endfunction

  function automatic void apply_op(logic [23:0] d);
    logic [1:0] kind;
    int a, b, cnt, top, got;
    kind = d[1:0];
    a    = int'(d[7:2]);
    b    = int'(d[13:8]);
    cnt  = int'(d[21:14]);
    top  = (a > b) ? a : b;
    case (kind)
      KIND_ADD_EDGE: begin
        if (top >= MAX_VERTICES) push_result(ST_CAPACITY, 0, degree_of(a), 0, 1'b1);
        else if (deg_tab[a] >= MAX_DEGREE || (a != b && deg_tab[b] >= MAX_DEGREE))
          push_result(ST_FULL, 0, degree_of(a), 0, 1'b1);
        else begin
          if (top + 1 > vert_cnt) vert_cnt = top + 1;
          adj_mem[a][deg_tab[a]] = b[5:0];
          deg_tab[a]++;
          if (a != b) begin
            adj_mem[b][deg_tab[b]] = a[5:0];
            deg_tab[b]++;
          end
          edge_cnt++;
          push_result(ST_OK, 0, degree_of(a), 0, 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (a >= vert_cnt || b >= vert_cnt) push_result(ST_RANGE, 0, degree_of(a), 0, 1'b1);
        else begin
          got = strip_matches(a, b, cnt);
          if (a != b) void'(strip_matches(b, a, cnt));
          edge_cnt = (edge_cnt >= got) ? edge_cnt - got : 0;
          push_result(ST_OK, 0, degree_of(a), got, 1'b1);
        end
      end
      KIND_ADD_VERT: begin
        if (vert_cnt + cnt > MAX_VERTICES) push_result(ST_CAPACITY, 0, degree_of(a), 0, 1'b1);
        else begin
          vert_cnt += cnt;
          push_result(ST_OK, 0, degree_of(a), 0, 1'b1);
        end
      end
      default: begin
        if (a >= vert_cnt) push_result(ST_RANGE, 0, 0, 0, 1'b1);
        else if (deg_tab[a] == 0) push_result(ST_OK, 0, 0, 0, 1'b1);
        else
          for (int i = 0; i < deg_tab[a]; i++)
            push_result(ST_OK, int'(adj_mem[a][i]), deg_tab[a], 0, i + 1 == deg_tab[a]);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    expected_t e;
    if (rst) begin
      expected_q.delete();
      for (int v = 0; v < MAX_VERTICES; v++) deg_tab[v] = 0;
      vert_cnt     = 0;
      edge_cnt     = 0;
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (s_tvalid && s_tready) apply_op(s_tdata);
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata[38:0] !== e.res || m_tdata[39] !== 1'b0 || m_tlast !== e.lst) begin
            $display("%0t: mismatch expected st %0d nb %0d dg %0d rm %0d vc %0d ec %0d last %b",
                     $time, e.res.status, e.res.neighbor, e.res.degree, e.res.removed,
                     e.res.vertex_count, e.res.edge_count, e.lst);
            $display("%0t:          actual   data %h last %b", $time, m_tdata, m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/undirected_adjacency_store_tb.sv -----
// Testbench top for the undirected adjacency store: clock, reset, stimulus
// and verdict. Depends on uas_pkg, undirected_adjacency_store and uas_checker.
`timescale 1ns / 1ps
module undirected_adjacency_store_tb
  import uas_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // kind, from_vertex, to_vertex, count from bit 0 up
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // status, neighbor, degree, removed, vertex_count, edge_count
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          items_sent;
  int          idle_cycles;
  bit          sink_hold;   // long receiver stall request
  bit          no_idle;     // stretch with no random idling

  undirected_adjacency_store DUT (.*);

  uas_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random backpressure, or a long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) m_tready <= 1'b0;
      else if (no_idle) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(99) >= 27);
    end
  end

  // long receiver stall while the sender keeps offering items
  initial begin
    sink_hold = 1'b0;
    @(posedge clk iff items_sent >= 100);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk);
    sink_hold = 1'b0;
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one item, holding it until accepted, with random gaps before it
  task automatic send_op(logic [1:0] kind, int a, int b, int cnt);
    while (!no_idle && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, cnt[7:0], b[5:0], a[5:0], kind};
    @(posedge clk iff s_tready);
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
  endtask

  // mostly small vertex numbers so lists fill and repeat edges appear
  function automatic int pick_vertex();
    if ($urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(7);
  endfunction

  initial begin
    int r;
    logic [1:0] kind;
    items_sent  = 0;
    no_idle     = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty graph, extremes, capacity, full list, self-loops
    send_op(KIND_LIST, 0, 0, 0);
    send_op(KIND_REMOVE, 0, 0, 1);
    send_op(KIND_ADD_VERT, 0, 0, 255);
    send_op(KIND_ADD_VERT, 63, 0, 0);
    send_op(KIND_ADD_EDGE, 63, 63, 0);
    send_op(KIND_ADD_EDGE, 0, 63, 255);
    send_op(KIND_LIST, 63, 0, 0);
    send_op(KIND_LIST, 5, 0, 0);
    send_op(KIND_ADD_VERT, 42, 21, 1);
    send_op(KIND_REMOVE, 63, 0, 0);
    send_op(KIND_REMOVE, 63, 63, 255);
    for (int i = 0; i < 33; i++) send_op(KIND_ADD_EDGE, 1, (i % 2) ? 2 : 1, 0);
    send_op(KIND_ADD_EDGE, 2, 3, 0);
    send_op(KIND_LIST, 1, 0, 0);
    send_op(KIND_REMOVE, 1, 2, 3);
    send_op(KIND_REMOVE, 2, 1, 255);
    send_op(KIND_LIST, 1, 0, 0);
    drain_results();

    // random: edge-heavy mix over a small vertex set; a stretch with no idling in the middle
    for (int n = 0; n < 410; n++) begin
      no_idle = (n >= 150 && n < 220);
      if (n == 300) drain_results();
      r = $urandom_range(99);
      kind = (r < 45) ? KIND_ADD_EDGE : (r < 65) ? KIND_REMOVE :
             (r < 75) ? KIND_ADD_VERT : KIND_LIST;
      send_op(kind, pick_vertex(), pick_vertex(),
              (kind == KIND_ADD_VERT && $urandom_range(3) != 0) ? $urandom_range(3)
                                                              : $urandom_range(255));
    end
    s_tvalid <= 1'b0;

    @(posedge clk iff pending == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d items, checked %0d results across all four operations,",
             items_sent, results_seen);
    $display("including capacity, full-list, range and self-loop cases.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
